[rtl/core/cse_pkg.sv]
// Shared types, constants and character tables for the C-string escape encoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cse_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned BUF_DEPTH_DEF   = 4096;
  localparam int unsigned LEN_WIDTH_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Fixed field widths of the ports
  localparam int unsigned CAP_W       = 13;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned TOTAL_LEN_W = 32;
  localparam int unsigned CHAR_W      = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  // Command codes
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TERM   = 2'd2,
    CMD_NONE   = 2'd3
  } cse_cmd_e;

  // Characters used by the escapes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_CTL_LO = 8'h0e;
  localparam logic [CHAR_W-1:0] CH_CTL_HI = 8'h1f;
  localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7f;
  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SOH    = 8'h01;

  // One classified item on its way from front to back
  typedef struct packed {
    logic [1:0]                   last_idx;  // number of characters minus one
    logic [3:0][CHAR_W-1:0]       chars;     // chars[0] goes out first
    logic [ADDR_W-1:0]            addr;      // offset of chars[0]
    logic                         wen;
    logic [TOTAL_LEN_W-1:0]       total_len;
  } cse_job_t;

  // One result word on the output side
  typedef struct packed {
    logic [CHAR_W-1:0]      out_char;
    logic [ADDR_W-1:0]      out_addr;
    logic                   write_en;
    logic [TOTAL_LEN_W-1:0] total_len;
    logic                   last_of_run;
  } cse_word_t;

  // Lowercase hex digit of a nibble
  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h57 + {4'd0, nib};
    end
    return ch;
  endfunction

  // Escape letter of tab through carriage return, by offset from tab
  function automatic logic [CHAR_W-1:0] ws_letter(input logic [2:0] idx);
    logic [CHAR_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h74;  // t
      3'd1:    ch = 8'h6e;  // n
      3'd2:    ch = 8'h76;  // v
      3'd3:    ch = 8'h66;  // f
      3'd4:    ch = 8'h72;  // r
      default: ch = 8'h74;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cse_front.sv]
// Front end of the escape encoder: takes words, classifies the byte, updates
// position and length, and hands a job to the queue. Depends on cse_pkg.
`default_nettype none

module cse_front #(
  parameter int unsigned BUF_DEPTH = cse_pkg::BUF_DEPTH_DEF,
  parameter int unsigned LEN_WIDTH = cse_pkg::LEN_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cse_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  wire logic                        push_i,
  input  wire logic                        q_full_i,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [cse_pkg::CHAR_W-1:0]  in_byte_i,
  output      logic                        q_push_o,
  output      cse_pkg::cse_job_t           q_job_o
);

  localparam int unsigned POS_W = (BUF_DEPTH > 2) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned EXT_W = POS_W + 2;

  logic [cse_pkg::CAP_W-1:0] cap_q;
  logic [POS_W-1:0]          wpos_q, wpos_d;
  logic [LEN_WIDTH-1:0]      len_q, len_d;

  logic [31:0]          cap_c, last_w;
  logic [POS_W-1:0]     last, pos;
  logic [EXT_W-1:0]     pos_e, last_e;
  logic [2:0]           len_inc;
  logic [LEN_WIDTH:0]   len_sum;
  logic [LEN_WIDTH-1:0] len_sat;
  logic                 is_hex, is_pair;
  logic [cse_pkg::CHAR_W-1:0] second;
  logic                 accept;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  // Write the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cse_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp capacity and current position to the last slot
  always_comb begin
    cap_c = 32'(cap_q);
    if (cap_c == 32'd0) begin
      cap_c = 32'd1;
    end
    if (cap_c > 32'(BUF_DEPTH)) begin
      cap_c = 32'(BUF_DEPTH);
    end
    last_w = cap_c - 32'd1;
    last   = last_w[POS_W-1:0];
    pos    = (wpos_q > last) ? last : wpos_q;
    pos_e  = {2'b00, pos};
    last_e = {2'b00, last};
  end

  // Classify the source byte
  always_comb begin
    is_hex = ((in_byte_i >= cse_pkg::CH_SOH) && (in_byte_i <= cse_pkg::CH_BS)) ||
             ((in_byte_i >= cse_pkg::CH_CTL_LO) && (in_byte_i <= cse_pkg::CH_CTL_HI)) ||
             (in_byte_i >= cse_pkg::CH_DEL);
    is_pair = (in_byte_i == cse_pkg::CH_NUL) ||
              ((in_byte_i >= cse_pkg::CH_TAB) && (in_byte_i <= cse_pkg::CH_CR)) ||
              (in_byte_i == cse_pkg::CH_BSLASH) || (in_byte_i == cse_pkg::CH_QUOTE);
    if (in_byte_i == cse_pkg::CH_NUL) begin
      second = cse_pkg::CH_ZERO;
    end else if ((in_byte_i >= cse_pkg::CH_TAB) && (in_byte_i <= cse_pkg::CH_CR)) begin
      second = cse_pkg::ws_letter(3'(in_byte_i - cse_pkg::CH_TAB));
    end else begin
      second = in_byte_i;
    end
  end

  // Saturating would-be length
  always_comb begin
    if (is_hex) begin
      len_inc = 3'd4;
    end else if (is_pair) begin
      len_inc = 3'd2;
    end else begin
      len_inc = 3'd1;
    end
    len_sum = {1'b0, len_q} + (LEN_WIDTH+1)'(len_inc);
    len_sat = len_sum[LEN_WIDTH] ? '1 : len_sum[LEN_WIDTH-1:0];
  end

  // Build the job and the next state
  always_comb begin
    wpos_d            = pos;
    len_d             = len_q;
    q_job_o.last_idx  = 2'd0;
    q_job_o.chars     = '0;
    q_job_o.addr      = cse_pkg::ADDR_W'(pos);
    q_job_o.wen       = 1'b0;
    case (cmd_i)
      cse_pkg::CMD_START: begin
        wpos_d       = '0;
        len_d        = '0;
        q_job_o.addr = '0;
      end
      cse_pkg::CMD_TERM: begin
        q_job_o.wen = 1'b1;
      end
      cse_pkg::CMD_APPEND: begin
        len_d = len_sat;
        if (is_hex) begin
          if ((pos_e + EXT_W'(3)) < last_e) begin
            q_job_o.last_idx = 2'd3;
            q_job_o.chars[0] = cse_pkg::CH_BSLASH;
            q_job_o.chars[1] = cse_pkg::CH_X;
            q_job_o.chars[2] = cse_pkg::hex_digit(in_byte_i[7:4]);
            q_job_o.chars[3] = cse_pkg::hex_digit(in_byte_i[3:0]);
            q_job_o.wen      = 1'b1;
            wpos_d           = POS_W'(pos_e + EXT_W'(4));
          end else begin
            wpos_d       = last;
            q_job_o.addr = cse_pkg::ADDR_W'(last);
          end
        end else if (is_pair) begin
          if ((pos_e + EXT_W'(1)) < last_e) begin
            q_job_o.last_idx = 2'd1;
            q_job_o.chars[0] = cse_pkg::CH_BSLASH;
            q_job_o.chars[1] = second;
            q_job_o.wen      = 1'b1;
            wpos_d           = POS_W'(pos_e + EXT_W'(2));
          end else begin
            wpos_d       = last;
            q_job_o.addr = cse_pkg::ADDR_W'(last);
          end
        end else begin
          q_job_o.chars[0] = in_byte_i;
          q_job_o.wen      = 1'b1;
          wpos_d = ((pos_e + EXT_W'(1)) < last_e) ? POS_W'(pos_e + EXT_W'(1)) : last;
        end
      end
      default: begin
        // unused command: report position and length only
      end
    endcase
    q_job_o.total_len = cse_pkg::TOTAL_LEN_W'(len_d);
  end

  // Advance position and length on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      len_q  <= '0;
    end else if (accept) begin
      wpos_q <= wpos_d;
      len_q  <= len_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/cse_fifo.sv]
// Short job queue between front and back of the escape encoder.
// Register-based circular buffer; depends on cse_pkg for the job type.
`default_nettype none

module cse_fifo #(
  parameter int unsigned DEPTH = cse_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire cse_pkg::cse_job_t job_i,
  output      logic              full_o,
  input  wire logic              pop_i,
  output      logic              valid_o,
  output      cse_pkg::cse_job_t job_o
);

  localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cse_pkg::cse_job_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/cse_back.sv]
// Back end of the escape encoder: walks each queued job into the output
// register, one character per cycle while pop is high. Depends on cse_pkg.
`default_nettype none

module cse_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire cse_pkg::cse_job_t head_i,
  output      logic              head_pop_o,
  output      logic              empty,
  input  wire logic              pop,
  output      cse_pkg::cse_word_t word_o
);

  logic               out_valid_q;
  cse_pkg::cse_word_t out_q, out_d;
  logic [1:0]         idx_q;
  logic               load, at_end;

  assign load       = head_valid_i && (!out_valid_q || pop);
  assign at_end     = (idx_q == head_i.last_idx);
  assign head_pop_o = load && at_end;
  assign empty      = !out_valid_q;
  assign word_o     = out_q;

  // Pick the current character of the head job
  always_comb begin
    out_d.out_char    = head_i.chars[idx_q];
    out_d.out_addr    = head_i.addr + cse_pkg::ADDR_W'(idx_q);
    out_d.write_en    = head_i.wen;
    out_d.total_len   = head_i.total_len;
    out_d.last_of_run = at_end;
  end

  // Load the output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  // Track output valid and the character index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A job half sent stays at the head of the queue
  a_mid_job_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> head_valid_i)
    else $error("head job vanished in the middle of its characters");

  // The index never runs past the head job's length
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q <= head_i.last_idx))
    else $error("character index past end of job");

  // The final character of a job is marked as last
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && at_end) |=> (out_valid_q && out_q.last_of_run))
    else $error("final character not marked last_of_run");
`endif

endmodule

`default_nettype wire

[rtl/core/c_string_escape_encoder.sv]
// Top level of the C-string escape encoder: front classifier, job queue and
// back serializer. Depends on cse_pkg, cse_front, cse_fifo and cse_back.
//
// Usage:
//   Input channel: present cmd_i/in_byte_i with push high; the word is taken
//   at a clock edge where full is low. Start clears position and length,
//   append escapes one byte, terminate stores a NUL at the current position.
//   Result channel: while empty is low the oldest result is on out_char_o,
//   out_addr_o, write_en_o, total_len_o and last_of_run_o; pop takes it.
//   Each input word yields one, two or four results, the last flagged by
//   last_of_run_o.
//   A taken word is written into the job queue; its first result then enters
//   the output register once it is free. Throughput: one result per cycle
//   while pop is high, set by the single-character output register.
//   The job queue (QUEUE_DEPTH entries) absorbs short bursts on either side.
//   Capacity: cfg_we_i writes cfg_wdata_i into the capacity register; write
//   it only while no results are outstanding.
//   Reset: clears position, length and queue; capacity returns to 4096.
//   Stall: with pop low the output holds, the queue fills, then full rises.
`default_nettype none

module c_string_escape_encoder #(
  parameter int unsigned BUF_DEPTH   = cse_pkg::BUF_DEPTH_DEF,
  parameter int unsigned LEN_WIDTH   = cse_pkg::LEN_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = cse_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cse_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  wire logic                             push,
  output      logic                             full,
  input  wire logic [1:0]                       cmd_i,
  input  wire logic [cse_pkg::CHAR_W-1:0]       in_byte_i,
  output      logic                             empty,
  input  wire logic                             pop,
  output      logic [cse_pkg::CHAR_W-1:0]       out_char_o,
  output      logic [cse_pkg::ADDR_W-1:0]       out_addr_o,
  output      logic                             write_en_o,
  output      logic [cse_pkg::TOTAL_LEN_W-1:0]  total_len_o,
  output      logic                             last_of_run_o
);

  logic               q_push, q_full, q_valid, q_pop;
  cse_pkg::cse_job_t  q_in, q_head;
  cse_pkg::cse_word_t word;

  assign full = q_full;

  // Classify and account
  cse_front #(
    .BUF_DEPTH (BUF_DEPTH),
    .LEN_WIDTH (LEN_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .q_full_i    (q_full),
    .cmd_i       (cmd_i),
    .in_byte_i   (in_byte_i),
    .q_push_o    (q_push),
    .q_job_o     (q_in)
  );

  // Decouple front and back
  cse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_head)
  );

  // Serialize characters
  cse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .head_pop_o   (q_pop),
    .empty        (empty),
    .pop          (pop),
    .word_o       (word)
  );

  assign out_char_o    = word.out_char;
  assign out_addr_o    = word.out_addr;
  assign write_en_o    = word.write_en;
  assign total_len_o   = word.total_len;
  assign last_of_run_o = word.last_of_run;

endmodule

`default_nettype wire
